>>> rtl/core/alsm_pkg.sv
// Shared types and constants of the acceleration-limited scroll motion engine.
`default_nettype none

package alsm_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int VEL_W      = 21;
	localparam int SPEED_W    = 20;
	localparam int ACCEL_W    = 24;
	localparam int DT_W       = 16;
	localparam int DIR_W      = 4;
	localparam int COORD_W    = 16;
	localparam int DELTA_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX     = 3'd5;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_PLACE = 1'b1;

	typedef enum logic [1:0] {
		MUL_STEP,
		MUL_VY,
		MUL_VX
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		logic     vel_upd;
		logic     pos_y_upd;
		logic     pos_x_upd;
		logic     place_upd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/alsm_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface alsm_in_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [alsm_pkg::DT_W-1:0]           dt;
	logic [alsm_pkg::DIR_W-1:0]          direction;
	logic signed [alsm_pkg::COORD_W-1:0] place_x;
	logic signed [alsm_pkg::COORD_W-1:0] place_y;

	modport source(output valid, output op, output dt, output direction,
		output place_x, output place_y, input ready);
	modport sink(input valid, input op, input dt, input direction,
		input place_x, input place_y, output ready);
endinterface

interface alsm_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [alsm_pkg::COORD_W-1:0] pos_x;
	logic signed [alsm_pkg::COORD_W-1:0] pos_y;
	logic signed [alsm_pkg::DELTA_W-1:0] delta_x;
	logic signed [alsm_pkg::DELTA_W-1:0] delta_y;
	logic                                moved;

	modport source(output valid, output pos_x, output pos_y, output delta_x,
		output delta_y, output moved, input ready);
	modport sink(input valid, input pos_x, input pos_y, input delta_x,
		input delta_y, input moved, output ready);
endinterface

`default_nettype wire

>>> rtl/core/accel_limited_scroll_motion.sv
// Top level of the two-axis acceleration-limited scroll motion engine.
//
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    op, dt, direction, place_x, place_y
//  out_ch    out   valid / ready    pos_x, pos_y, delta_x, delta_y, moved
//  cfg       in    cfg_we only      cfg_index, cfg_data
//
// A tick beat steps through S_STEP, S_VEL, S_MULY, S_MULX, S_POSX and S_FIN before the next is accepted:
// one shared 25x17 multiplier forms accel*dt, then vel_y*dt, then vel_x*dt.
// A place beat steps through S_PLACE and S_FIN. The result register frees the sequencer once
// loaded, so the next beat is accepted while the result waits to be taken.
// A stalled output holds the sequencer in its final state. Asynchronous reset
// clears velocity, position, bounds and speed settings to zero at once.
`default_nettype none

module accel_limited_scroll_motion #(
	parameter int FRAC_BITS = alsm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	alsm_in_if.sink                              in_ch,
	alsm_out_if.source                           out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [alsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [alsm_pkg::CFG_DATA_W-1:0] cfg_data
);

	alsm_pkg::cmd_t    cmd;
	alsm_pkg::status_t status;
	logic              in_ready;

	assign in_ch.ready = in_ready;

	alsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_op    (in_ch.op),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	alsm_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_op        (in_ch.op),
		.in_dt        (in_ch.dt),
		.in_direction (in_ch.direction),
		.in_place_x   (in_ch.place_x),
		.in_place_y   (in_ch.place_y),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_pos_x    (out_ch.pos_x),
		.out_pos_y    (out_ch.pos_y),
		.out_delta_x  (out_ch.delta_x),
		.out_delta_y  (out_ch.delta_y),
		.out_moved    (out_ch.moved)
	);

endmodule

`default_nettype wire

>>> rtl/core/alsm_ctrl.sv
// Sequencer that steps one item at a time through the shared multiplier datapath.
`default_nettype none

module alsm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_op,
	output logic                   in_ready,
	output alsm_pkg::cmd_t         cmd,
	input  wire alsm_pkg::status_t status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_VEL,
		S_MULY,
		S_MULX,
		S_POSX,
		S_PLACE,
		S_FIN
	} state_t;

	state_t state_q;
	logic   in_beat;

	assign in_ready = (state_q == S_IDLE);
	assign in_beat  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= (in_op == alsm_pkg::OP_PLACE) ? S_PLACE : S_STEP;
					end
				end
				S_STEP:  state_q <= S_VEL;
				S_VEL:   state_q <= S_MULY;
				S_MULY:  state_q <= S_MULX;
				S_MULX:  state_q <= S_POSX;
				S_POSX:  state_q <= S_FIN;
				S_PLACE: state_q <= S_FIN;
				S_FIN: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = alsm_pkg::MUL_STEP;
		cmd.capture   = in_beat;
		case (state_q)
			S_STEP:  cmd.mul_sel = alsm_pkg::MUL_STEP;
			S_VEL:   cmd.vel_upd = 1'b1;
			S_MULY:  cmd.mul_sel = alsm_pkg::MUL_VY;
			S_MULX: begin
				cmd.mul_sel   = alsm_pkg::MUL_VX;
				cmd.pos_y_upd = 1'b1;
			end
			S_POSX:  cmd.pos_x_upd = 1'b1;
			S_PLACE: cmd.place_upd = 1'b1;
			S_FIN:   cmd.out_load  = status.out_free;
			default: cmd.capture   = in_beat;
		endcase
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded while the output register is occupied");
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("input ready again right after an accepted beat");
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.vel_upd, cmd.pos_y_upd, cmd.pos_x_upd, cmd.place_upd,
			cmd.out_load, cmd.capture}))
		else $error("more than one datapath update in a cycle");
	a_load_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> in_ready)
		else $error("sequencer not idle after delivering a result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/alsm_datapath.sv
// Datapath: registers, shared multiplier, velocity and position update, result register.
`default_nettype none

module alsm_datapath #(
	parameter int FRAC_BITS = alsm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire alsm_pkg::cmd_t                      cmd,
	output alsm_pkg::status_t                        status,
	input  wire logic                                cfg_we,
	input  wire logic [alsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [alsm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_op,
	input  wire logic [alsm_pkg::DT_W-1:0]           in_dt,
	input  wire logic [alsm_pkg::DIR_W-1:0]          in_direction,
	input  wire logic signed [alsm_pkg::COORD_W-1:0] in_place_x,
	input  wire logic signed [alsm_pkg::COORD_W-1:0] in_place_y,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [alsm_pkg::COORD_W-1:0]      out_pos_x,
	output logic signed [alsm_pkg::COORD_W-1:0]      out_pos_y,
	output logic signed [alsm_pkg::DELTA_W-1:0]      out_delta_x,
	output logic signed [alsm_pkg::DELTA_W-1:0]      out_delta_y,
	output logic                                     out_moved
);

	localparam int VW   = alsm_pkg::VEL_W;
	localparam int CW   = alsm_pkg::COORD_W;
	localparam int FW   = CW + FRAC_BITS;
	localparam int MAW  = alsm_pkg::ACCEL_W + 1;
	localparam int MBW  = alsm_pkg::DT_W + 1;
	localparam int PRW  = MAW + MBW;
	localparam int RSW  = PRW - alsm_pkg::DT_W;
	localparam int SW   = ((FW > RSW) ? FW : RSW) + 1;
	localparam logic [1:0] DIR_NEG = 2'b01;
	localparam logic [1:0] DIR_POS = 2'b10;
	localparam logic signed [PRW-1:0] RND_HALF = PRW'(1) << (alsm_pkg::DT_W - 1);
	localparam logic signed [FW:0]    POS_HALF = (FW+1)'(1) << (FRAC_BITS - 1);

	// Configuration registers.
	logic [alsm_pkg::SPEED_W-1:0] max_speed_q;
	logic [alsm_pkg::ACCEL_W-1:0] accel_q;
	logic signed [CW-1:0]         x_min_q, x_max_q, y_min_q, y_max_q;

	// Captured input beat.
	logic [alsm_pkg::DT_W-1:0]    dt_q;
	logic [alsm_pkg::DIR_W-1:0]   dir_q;
	logic signed [CW-1:0]         place_x_q, place_y_q;

	// Motion state.
	logic signed [VW-1:0]         vel_x_q, vel_y_q;
	logic signed [FW-1:0]         fine_x_q, fine_y_q;
	logic signed [CW-1:0]         last_x_q, last_y_q;
	logic signed [PRW-1:0]        prod_q;

	logic signed [MAW-1:0]        mul_a;
	logic signed [MBW-1:0]        mul_b;
	logic signed [PRW-1:0]        prod_rnd;
	logic signed [RSW-1:0]        prod_sh;
	logic signed [SW-1:0]         py_in, px_in;
	logic [FW:0]                  cy, cx;
	logic signed [FW:0]           rnd_x, rnd_y;
	logic signed [CW-1:0]         px, py;
	logic signed [alsm_pkg::DELTA_W-1:0] dx, dy;

	function automatic logic signed [VW-1:0] vel_next(
		input logic signed [VW-1:0]           v,
		input logic [1:0]                     dirs,
		input logic [alsm_pkg::SPEED_W-1:0]   ms,
		input logic signed [RSW-1:0]          step
	);
		logic signed [RSW-1:0] vv, tt, d, r;
		vv = RSW'(v);
		tt = '0;
		if (dirs == DIR_NEG) tt = -$signed(RSW'(ms));
		if (dirs == DIR_POS) tt = $signed(RSW'(ms));
		r = vv;
		if (vv > tt) begin
			d = vv - step;
			r = (d < tt) ? tt : d;
		end else if (vv < tt) begin
			d = vv + step;
			r = (d > tt) ? tt : d;
		end
		return r[VW-1:0];
	endfunction

	// Returns the clamped position with a flag on top that says a bound was hit.
	function automatic logic [FW:0] clamp_fn(
		input logic signed [SW-1:0] p,
		input logic signed [CW-1:0] lo,
		input logic signed [CW-1:0] hi
	);
		logic signed [SW-1:0] lo_f, hi_f, r;
		logic                 z;
		lo_f = SW'(lo) <<< FRAC_BITS;
		hi_f = SW'(hi) <<< FRAC_BITS;
		r = p;
		z = 1'b0;
		if (r < lo_f) begin
			r = lo_f;
			z = 1'b1;
		end
		if (r > hi_f) begin
			r = hi_f;
			z = 1'b1;
		end
		return {z, r[FW-1:0]};
	endfunction

	always_comb begin
		case (cmd.mul_sel)
			alsm_pkg::MUL_STEP: mul_a = $signed({1'b0, accel_q});
			alsm_pkg::MUL_VY:   mul_a = MAW'(vel_y_q);
			alsm_pkg::MUL_VX:   mul_a = MAW'(vel_x_q);
			default:            mul_a = '0;
		endcase
	end

	assign mul_b    = $signed({1'b0, dt_q});
	// Round to nearest with ties upward, then drop the Q0.16 time fraction.
	assign prod_rnd = prod_q + RND_HALF;
	assign prod_sh  = prod_rnd[PRW-1:alsm_pkg::DT_W];

	always_comb begin
		if (cmd.place_upd) begin
			py_in = SW'(place_y_q) <<< FRAC_BITS;
			px_in = SW'(place_x_q) <<< FRAC_BITS;
		end else begin
			py_in = SW'(fine_y_q) + SW'(prod_sh);
			px_in = SW'(fine_x_q) + SW'(prod_sh);
		end
		cy = clamp_fn(py_in, y_min_q, y_max_q);
		cx = clamp_fn(px_in, x_min_q, x_max_q);
	end

	assign rnd_x = (FW+1)'(fine_x_q) + POS_HALF;
	assign rnd_y = (FW+1)'(fine_y_q) + POS_HALF;
	assign px    = rnd_x[FRAC_BITS+CW-1:FRAC_BITS];
	assign py    = rnd_y[FRAC_BITS+CW-1:FRAC_BITS];
	assign dx    = alsm_pkg::DELTA_W'(px) - alsm_pkg::DELTA_W'(last_x_q);
	assign dy    = alsm_pkg::DELTA_W'(py) - alsm_pkg::DELTA_W'(last_y_q);

	assign status.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= '0;
			accel_q     <= '0;
			x_min_q     <= '0;
			x_max_q     <= '0;
			y_min_q     <= '0;
			y_max_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				alsm_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data[alsm_pkg::SPEED_W-1:0];
				alsm_pkg::CFG_ACCEL:     accel_q     <= cfg_data[alsm_pkg::ACCEL_W-1:0];
				alsm_pkg::CFG_X_MIN:     x_min_q     <= $signed(cfg_data[CW-1:0]);
				alsm_pkg::CFG_X_MAX:     x_max_q     <= $signed(cfg_data[CW-1:0]);
				alsm_pkg::CFG_Y_MIN:     y_min_q     <= $signed(cfg_data[CW-1:0]);
				alsm_pkg::CFG_Y_MAX:     y_max_q     <= $signed(cfg_data[CW-1:0]);
				default: ;
			endcase
		end
	end

	// The op bit is not kept here; it steers the sequencer and zeroes dt_q for a place beat.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dt_q      <= (in_op == alsm_pkg::OP_TICK) ? in_dt : '0;
			dir_q     <= in_direction;
			place_x_q <= in_place_x;
			place_y_q <= in_place_y;
		end
		prod_q <= mul_a * mul_b;
		if (cmd.out_load) begin
			out_pos_x   <= px;
			out_pos_y   <= py;
			out_delta_x <= dx;
			out_delta_y <= dy;
			out_moved   <= (dx != '0) || (dy != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_x_q   <= '0;
			vel_y_q   <= '0;
			fine_x_q  <= '0;
			fine_y_q  <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.vel_upd) begin
				vel_y_q <= vel_next(vel_y_q, dir_q[1:0], max_speed_q, prod_sh);
				vel_x_q <= vel_next(vel_x_q, dir_q[3:2], max_speed_q, prod_sh);
			end
			if (cmd.pos_y_upd || cmd.place_upd) begin
				fine_y_q <= $signed(cy[FW-1:0]);
				if (cy[FW]) vel_y_q <= '0;
			end
			if (cmd.pos_x_upd || cmd.place_upd) begin
				fine_x_q <= $signed(cx[FW-1:0]);
				if (cx[FW]) vel_x_q <= '0;
			end
			if (cmd.out_load) begin
				last_x_q  <= px;
				last_y_q  <= py;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_vel_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place_upd |=> (vel_y_q == $past(vel_y_q)) || (vel_y_q == '0))
		else $error("place changed the vertical velocity other than by a clamp");
	a_moved_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.out_load) |-> out_moved == ((out_delta_x != '0) || (out_delta_y != '0)))
		else $error("moved flag disagrees with the deltas");
	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.out_load) |-> (last_x_q == out_pos_x) && (last_y_q == out_pos_y))
		else $error("last position not taken from the delivered result");
`endif

endmodule

`default_nettype wire
